FILE: rtl/core/sprite_quad_corner_transform_defines.svh
// ----------------------------------------------------------------------------
// Sprite quad corner transform: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef SPRITE_QUAD_CORNER_TRANSFORM_DEFINES_SVH
`define SPRITE_QUAD_CORNER_TRANSFORM_DEFINES_SVH

// same-cycle implication, off while reset is low
`define SQCT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication, off while reset is low
`define SQCT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication, always active (reset behavior)
`define SQCT_ASSERT_RST(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: reset check failed");

`endif

FILE: rtl/core/sqct_pkg.sv
// ----------------------------------------------------------------------------
// Sprite quad corner transform package
// Payload types, trig constants and the quarter-wave sine table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sqct_pkg;

    // input item: one sprite
    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic        [11:0] half_width;
        logic        [11:0] half_height;
        logic signed [15:0] pivot_x;
        logic signed [15:0] pivot_y;
        logic               flip_x;
        logic               flip_y;
        logic        [8:0]  angle_deg;
    } t_in_item;

    // result item: four corners
    typedef struct packed {
        logic signed [15:0] corner0_x;
        logic signed [15:0] corner0_y;
        logic signed [15:0] corner1_x;
        logic signed [15:0] corner1_y;
        logic signed [15:0] corner2_x;
        logic signed [15:0] corner2_y;
        logic signed [15:0] corner3_x;
        logic signed [15:0] corner3_y;
    } t_out_item;

    // load enables of the rotation stages
    typedef struct packed {
        logic en_mul;
        logic en_sum;
        logic en_out;
    } t_pipe_ctl;

    localparam int unsigned QUARTER_DEG   = 90;
    localparam int unsigned DEG_HALF_TURN = 180;
    localparam int unsigned FULL_DEG      = 360;
    localparam int unsigned TRIG_ONE      = 16384;
    localparam int unsigned TRIG_SHIFT    = 14;

    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint unsigned Q30_ONE = 64'd1073741824;

    // quadrant codes
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef logic [14:0] t_trig_tab [0:90];

    // shift-subtract quotient, only evaluated while the table is elaborated
    function automatic longint unsigned div_u64(input longint unsigned num,
                                                input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 0;
        rem = 0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            quo = {quo[62:0], 1'b0};
            if (rem >= den) begin
                rem    = rem - den;
                quo[0] = 1'b1;
            end
        end
        return quo;
    endfunction

    // round(16384 * sin(d deg)), d = 0..90, from a Q30 Taylor series
    function automatic t_trig_tab build_trig_tab();
        t_trig_tab       tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        for (int d = 0; d <= 90; d++) begin
            x    = div_u64(longint'(d) * PI_Q30, longint'(DEG_HALF_TURN));
            x2   = (x * x) >> 30;
            term = x;
            sum  = 0;
            for (int n = 1; n < 14; n++) begin
                if (term != 0) begin
                    if ((n % 2) == 1) sum = sum + longint'(term);
                    else              sum = sum - longint'(term);
                    term = div_u64((term * x2) >> 30,
                                   longint'(2 * n) * longint'(2 * n + 1));
                end
            end
            if (sum < 0) sum = 0;
            tab[d] = 15'((longint'(sum) * TRIG_ONE + Q30_ONE / 2) >> 30);
        end
        return tab;
    endfunction

    localparam t_trig_tab TRIG_TAB = build_trig_tab();

endpackage

`default_nettype wire

FILE: rtl/core/sqct_if.sv
// ----------------------------------------------------------------------------
// Sprite quad corner transform channels
// Valid/ready interfaces for the sprite input and the corner output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sqct_in_if;
    import sqct_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sqct_out_if;
    import sqct_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sqct_corner.sv
// ----------------------------------------------------------------------------
// Sprite quad corner transform: corner rotator
// Rotates one corner, rounds to Q12.4, adds the position and saturates.
// Three register stages: products, sums, saturated output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sqct_corner #(
    parameter int CW = 17
) (
    input  wire                     i_clk,
    input  wire sqct_pkg::t_pipe_ctl i_ctl,
    input  wire logic signed [CW-1:0] i_x,
    input  wire logic signed [CW-1:0] i_y,
    input  wire logic signed [15:0] i_cos,
    input  wire logic signed [15:0] i_sin,
    input  wire logic signed [15:0] i_pos_x,
    input  wire logic signed [15:0] i_pos_y,
    output logic signed [15:0]      o_x,
    output logic signed [15:0]      o_y
);
    import sqct_pkg::*;

    localparam int PW = CW + 16;         // product width
    localparam int AW = CW + 17;         // sum width
    localparam int SW = AW - TRIG_SHIFT; // shifted sum width
    localparam int EW = SW + 1;          // after position add
    localparam logic signed [AW-1:0] ROUND_HALF = AW'(TRIG_ONE / 2);
    localparam logic signed [EW-1:0] SAT_MAX = EW'(32767);
    localparam logic signed [EW-1:0] SAT_MIN = -EW'(32768);

    logic signed [PW-1:0] r_xc, r_ys, r_xs, r_yc;
    logic signed [15:0]   r_pos_x3, r_pos_y3, r_pos_x4, r_pos_y4;
    logic signed [AW-1:0] r_sum_x, r_sum_y;
    logic signed [AW-1:0] n_sum_x, n_sum_y;
    logic signed [SW-1:0] sh_x, sh_y;
    logic signed [EW-1:0] ext_x, ext_y;
    logic signed [15:0]   n_x, n_y;

    // stage 3: four products
    always_ff @(posedge i_clk) begin
        if (i_ctl.en_mul) begin
            r_xc     <= i_x * i_cos;
            r_ys     <= i_y * i_sin;
            r_xs     <= i_x * i_sin;
            r_yc     <= i_y * i_cos;
            r_pos_x3 <= i_pos_x;
            r_pos_y3 <= i_pos_y;
        end
    end

    // stage 4: rotation sums with the rounding offset
    assign n_sum_x = AW'(r_xc) - AW'(r_ys) + ROUND_HALF;
    assign n_sum_y = AW'(r_xs) + AW'(r_yc) + ROUND_HALF;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_sum) begin
            r_sum_x  <= n_sum_x;
            r_sum_y  <= n_sum_y;
            r_pos_x4 <= r_pos_x3;
            r_pos_y4 <= r_pos_y3;
        end
    end

    // stage 5: floor shift, position add, saturate
    assign sh_x  = $signed(r_sum_x[AW-1:TRIG_SHIFT]);
    assign sh_y  = $signed(r_sum_y[AW-1:TRIG_SHIFT]);
    assign ext_x = EW'(sh_x) + EW'(r_pos_x4);
    assign ext_y = EW'(sh_y) + EW'(r_pos_y4);

    always_comb begin
        if (ext_x > SAT_MAX)      n_x = 16'sh7fff;
        else if (ext_x < SAT_MIN) n_x = 16'sh8000;
        else                      n_x = ext_x[15:0];
        if (ext_y > SAT_MAX)      n_y = 16'sh7fff;
        else if (ext_y < SAT_MIN) n_y = 16'sh8000;
        else                      n_y = ext_y[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_out) begin
            o_x <= n_x;
            o_y <= n_y;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/sprite_quad_corner_transform.sv
// Takes one sprite per clock while the output is not stalled and returns its
// four quad corners, rotated about the pivot and moved to the sprite position,
// through five register stages. The rate is one sprite per cycle, set by the
// sixteen 16-bit by corner-width multipliers of the product stage, one set per
// stage. Stages are angle reduction and corner setup, sine/cosine table lookup,
// products, sums, and rounding with saturation into the output register. A
// stalled output holds only the full stages behind it, so bubbles are squeezed
// out and input stays open until all five stages hold a sprite.
// ----------------------------------------------------------------------------
// Sprite quad corner transform
// Quad corner generation, rotation by whole degrees and saturation to Q12.4.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sprite_quad_corner_transform #(
    parameter int FRAC_BITS = 4
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    sqct_in_if.sink     i_in,
    sqct_out_if.source  o_out
);
    import sqct_pkg::*;

    localparam int HW_W = 12 + FRAC_BITS;
    localparam int CW   = ((HW_W > 15) ? HW_W : 15) + 2;
    localparam int NSTG = 5;

    // pipeline valid bits and load enables
    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] stage_en;
    t_pipe_ctl       ctl;

    always_comb begin
        stage_en[NSTG-1] = !r_v[NSTG-1] || o_out.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            stage_en[k] = !r_v[k] || stage_en[k+1];
        end
    end

    assign i_in.ready  = stage_en[0];
    assign o_out.valid = r_v[NSTG-1];
    assign ctl.en_mul  = stage_en[2];
    assign ctl.en_sum  = stage_en[3];
    assign ctl.en_out  = stage_en[4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (stage_en[0]) r_v[0] <= i_in.valid;
            for (int k = 1; k < NSTG; k++) begin
                if (stage_en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // stage 1: angle reduction and unrotated corners
    logic [8:0]           ang;
    logic [1:0]           n_quad;
    logic [6:0]           n_rem;
    logic signed [CW-1:0] hw, hh, pvx, pvy;
    logic signed [CW-1:0] n_cx [4];
    logic signed [CW-1:0] n_cy [4];

    always_comb begin
        ang = (i_in.data.angle_deg >= 9'(FULL_DEG)) ?
              i_in.data.angle_deg - 9'(FULL_DEG) : i_in.data.angle_deg;
        if (ang >= 9'(3 * QUARTER_DEG)) begin
            n_quad = QUAD_3;
            n_rem  = 7'(ang - 9'(3 * QUARTER_DEG));
        end else if (ang >= 9'(2 * QUARTER_DEG)) begin
            n_quad = QUAD_2;
            n_rem  = 7'(ang - 9'(2 * QUARTER_DEG));
        end else if (ang >= 9'(QUARTER_DEG)) begin
            n_quad = QUAD_1;
            n_rem  = 7'(ang - 9'(QUARTER_DEG));
        end else begin
            n_quad = QUAD_0;
            n_rem  = ang[6:0];
        end
    end

    assign hw  = $signed(CW'(i_in.data.half_width))  <<< FRAC_BITS;
    assign hh  = $signed(CW'(i_in.data.half_height)) <<< FRAC_BITS;
    assign pvx = CW'(i_in.data.pivot_x);
    assign pvy = CW'(i_in.data.pivot_y);

    // corner order: (-w,-h), (w,-h), (w,h), (-w,h); flip_x negates y, flip_y x
    always_comb begin
        n_cx[0] = -hw - pvx;
        n_cx[1] =  hw - pvx;
        n_cx[2] =  hw - pvx;
        n_cx[3] = -hw - pvx;
        n_cy[0] = -hh - pvy;
        n_cy[1] = -hh - pvy;
        n_cy[2] =  hh - pvy;
        n_cy[3] =  hh - pvy;
        for (int k = 0; k < 4; k++) begin
            if (i_in.data.flip_y) n_cx[k] = -n_cx[k];
            if (i_in.data.flip_x) n_cy[k] = -n_cy[k];
        end
    end

    logic [1:0]           r_quad;
    logic [6:0]           r_rem;
    logic signed [CW-1:0] r_cx1 [4];
    logic signed [CW-1:0] r_cy1 [4];
    logic signed [15:0]   r_pos_x1, r_pos_y1;

    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            r_quad   <= n_quad;
            r_rem    <= n_rem;
            r_cx1    <= n_cx;
            r_cy1    <= n_cy;
            r_pos_x1 <= i_in.data.pos_x;
            r_pos_y1 <= i_in.data.pos_y;
        end
    end

    // stage 2: table lookup and quadrant signs
    logic signed [15:0] sr, cr, n_cos, n_sin;

    assign sr = $signed({1'b0, TRIG_TAB[r_rem]});
    assign cr = $signed({1'b0, TRIG_TAB[7'(QUARTER_DEG) - r_rem]});

    always_comb begin
        case (r_quad)
            QUAD_0:  begin n_sin =  sr; n_cos =  cr; end
            QUAD_1:  begin n_sin =  cr; n_cos = -sr; end
            QUAD_2:  begin n_sin = -sr; n_cos = -cr; end
            QUAD_3:  begin n_sin = -cr; n_cos =  sr; end
            default: begin n_sin =  sr; n_cos =  cr; end
        endcase
    end

    logic signed [15:0]   r_cos, r_sin, r_pos_x2, r_pos_y2;
    logic signed [CW-1:0] r_cx2 [4];
    logic signed [CW-1:0] r_cy2 [4];

    always_ff @(posedge i_clk) begin
        if (stage_en[1]) begin
            r_cos    <= n_cos;
            r_sin    <= n_sin;
            r_cx2    <= r_cx1;
            r_cy2    <= r_cy1;
            r_pos_x2 <= r_pos_x1;
            r_pos_y2 <= r_pos_y1;
        end
    end

    // stages 3 to 5: one rotator per corner
    logic signed [15:0] rx [4];
    logic signed [15:0] ry [4];

    for (genvar g = 0; g < 4; g++) begin : g_corner
        sqct_corner #(
            .CW (CW)
        ) u_corner (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_x     (r_cx2[g]),
            .i_y     (r_cy2[g]),
            .i_cos   (r_cos),
            .i_sin   (r_sin),
            .i_pos_x (r_pos_x2),
            .i_pos_y (r_pos_y2),
            .o_x     (rx[g]),
            .o_y     (ry[g])
        );
    end

    assign o_out.data.corner0_x = rx[0];
    assign o_out.data.corner0_y = ry[0];
    assign o_out.data.corner1_x = rx[1];
    assign o_out.data.corner1_y = ry[1];
    assign o_out.data.corner2_x = rx[2];
    assign o_out.data.corner2_y = ry[2];
    assign o_out.data.corner3_x = rx[3];
    assign o_out.data.corner3_y = ry[3];

endmodule

`default_nettype wire

FILE: rtl/core/sqct_checker.sv
// ----------------------------------------------------------------------------
// Sprite quad corner transform checker
// Port-level checks on occupancy, back-pressure and reset, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sprite_quad_corner_transform_defines.svh"

module sqct_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_in_valid,
    input wire                  i_in_ready,
    input wire                  i_out_valid,
    input wire                  i_out_ready,
    input wire sqct_pkg::t_out_item i_out_data
);
    import sqct_pkg::*;

    localparam int PIPE_DEPTH = 5;

    logic       in_xfer, out_xfer;
    logic [2:0] r_cnt;
    logic [2:0] n_cnt;

    assign in_xfer  = i_in_valid && i_in_ready;
    assign out_xfer = i_out_valid && i_out_ready;

    // sprites in flight
    always_comb begin
        n_cnt = r_cnt;
        if (in_xfer && !out_xfer)      n_cnt = r_cnt + 3'd1;
        else if (!in_xfer && out_xfer) n_cnt = r_cnt - 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // a result only appears for a sprite that went in
    `SQCT_ASSERT_IMP(a_out_has_src, i_clk, i_rst_n, i_out_valid, r_cnt != 3'd0)
    // never more sprites in flight than stages
    `SQCT_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= 3'(PIPE_DEPTH))
    // input closes only when the pipe is blocked at the output
    `SQCT_ASSERT_IMP(a_no_bubble_stall, i_clk, i_rst_n, !i_in_ready,
                     i_out_valid && !i_out_ready)
    // a stalled result holds
    `SQCT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
                     i_out_valid && $stable(i_out_data))
    // reset empties the pipe
    `SQCT_ASSERT_RST(a_rst_empty, i_clk, !i_rst_n, !i_out_valid)

endmodule

bind sprite_quad_corner_transform sqct_checker u_sqct_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

`default_nettype wire

FILE: bench/sqct_corner_checker.sv
// ----------------------------------------------------------------------------
// Sprite quad corner checker
// Watches the sprite and corner channels. Each accepted sprite is run through
// an independent integer model of the transform: corner setup, pivot, flips,
// Q1.14 rotation with round-half-up, then the position add with saturation.
// Each accepted corner result is compared field by field with the oldest
// prediction in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sqct_corner_checker #(
    parameter int FRAC_BITS = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sqct_in_if   i_sprite,
    sqct_out_if  i_corner,
    output int   o_mismatches,
    output int   o_pending
);
    import sqct_pkg::*;

    localparam int     REPORT_LIMIT = 10;
    localparam longint ROUND_HALF   = longint'(TRIG_ONE / 2);

    longint    sine_q14 [0:QUARTER_DEG];
    t_out_item predicted_corners [$];
    int        sprites_seen  = 0;
    int        results_taken = 0;
    int        mismatch_cnt  = 0;

    assign o_mismatches = mismatch_cnt;
    assign o_pending    = sprites_seen - results_taken;

    // round(16384 * sin(deg)) from a Q30 power series, deg in 0..90
    function automatic longint quarter_sine(input int unsigned deg);
        longint unsigned rad;
        longint unsigned rad_sq;
        longint unsigned term;
        longint          acc;
        rad    = (64'(deg) * PI_Q30) / DEG_HALF_TURN;
        rad_sq = (rad * rad) >> 30;
        term   = rad;
        acc    = 0;
        for (int n = 1; n < 14 && term != 0; n++) begin
            if ((n % 2) == 1) acc = acc + longint'(term);
            else              acc = acc - longint'(term);
            term = ((term * rad_sq) >> 30) / (64'(2 * n) * 64'(2 * n + 1));
        end
        if (acc < 0) acc = 0;
        return longint'((64'(acc) * TRIG_ONE + Q30_ONE / 2) >> 30);
    endfunction

    initial begin
        for (int d = 0; d <= QUARTER_DEG; d++) sine_q14[d] = quarter_sine(d);
    end

    function automatic logic [15:0] clamp_q12_4(input longint v);
        if (v > 32767)  return 16'h7FFF;
        if (v < -32768) return 16'h8000;
        return 16'(v);
    endfunction

    // four transformed corners of one sprite
    function automatic t_out_item corners_of(input t_in_item s);
        logic [15:0] res [8];
        longint      cos_v;
        longint      sin_v;
        longint      hw;
        longint      hh;
        longint      cx;
        longint      cy;
        longint      rx;
        longint      ry;
        int unsigned ang;
        int unsigned rem;
        ang = s.angle_deg % FULL_DEG;
        rem = ang % QUARTER_DEG;
        case (2'(ang / QUARTER_DEG))
            QUAD_0: begin
                sin_v = sine_q14[rem];
                cos_v = sine_q14[QUARTER_DEG - rem];
            end
            QUAD_1: begin
                sin_v = sine_q14[QUARTER_DEG - rem];
                cos_v = -sine_q14[rem];
            end
            QUAD_2: begin
                sin_v = -sine_q14[rem];
                cos_v = -sine_q14[QUARTER_DEG - rem];
            end
            default: begin
                sin_v = -sine_q14[QUARTER_DEG - rem];
                cos_v = sine_q14[rem];
            end
        endcase
        hw = longint'(s.half_width) << FRAC_BITS;
        hh = longint'(s.half_height) << FRAC_BITS;
        for (int k = 0; k < 4; k++) begin
            cx = (k == 1 || k == 2) ? hw : -hw;
            cy = (k >= 2) ? hh : -hh;
            cx = cx - longint'($signed(s.pivot_x));
            cy = cy - longint'($signed(s.pivot_y));
            // flip_x mirrors y, flip_y mirrors x
            if (s.flip_x) cy = -cy;
            if (s.flip_y) cx = -cx;
            rx = (cx * cos_v - cy * sin_v + ROUND_HALF) >>> TRIG_SHIFT;
            ry = (cx * sin_v + cy * cos_v + ROUND_HALF) >>> TRIG_SHIFT;
            res[2 * k]     = clamp_q12_4(rx + longint'($signed(s.pos_x)));
            res[2 * k + 1] = clamp_q12_4(ry + longint'($signed(s.pos_y)));
        end
        return {res[0], res[1], res[2], res[3], res[4], res[5], res[6], res[7]};
    endfunction

    task automatic compare_corners(input t_out_item got);
        t_out_item   want;
        logic [15:0] want_f;
        logic [15:0] got_f;
        if (predicted_corners.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_LIMIT)
                $display("unexpected corner transfer: %h", got);
            return;
        end
        want = predicted_corners.pop_front();
        results_taken++;
        for (int k = 0; k < 8; k++) begin
            want_f = want[127 - 16 * k -: 16];
            got_f  = got[127 - 16 * k -: 16];
            if (want_f !== got_f) begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_LIMIT)
                    $display("result %0d corner%0d_%s: expected %0d, got %0d",
                             results_taken - 1, k / 2, (k % 2) ? "y" : "x",
                             $signed(want_f), $signed(got_f));
            end
        end
    endtask

    // result side first: a sprite taken this edge cannot already be out
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_corner.valid && i_corner.ready) compare_corners(i_corner.data);
            if (i_sprite.valid && i_sprite.ready) begin
                predicted_corners.insert(predicted_corners.size(),
                                         corners_of(i_sprite.data));
                sprites_seen++;
            end
        end
    end

endmodule

FILE: bench/tb_sprite_quad_corner_transform.sv
// ----------------------------------------------------------------------------
// Sprite quad corner transform testbench
// Directed sprites (extremes, quadrants, angle wrap, flips, saturation) then
// random sprites with random bursts of idle on both channels. The checker
// predicts and compares; this module drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sprite_quad_corner_transform;
    import sqct_pkg::*;

    localparam int FRAC_BITS      = 4;
    localparam int RANDOM_SPRITES = 1430;
    localparam int QUIET_TAIL     = 150;
    localparam int STALL_LIMIT    = 1000;
    localparam int DRAIN_CYCLES   = 10;

    logic i_clk;
    logic i_rst_n;
    int   sprites_sent = 0;
    int   quiet_from   = 1 << 30;
    int   idle_cycles  = 0;
    int   mismatches;
    int   pending;
    logic quiet;

    assign quiet = (sprites_sent >= quiet_from);

    sqct_in_if  sprite_ch ();
    sqct_out_if corner_ch ();

    sprite_quad_corner_transform #(
        .FRAC_BITS (FRAC_BITS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (sprite_ch),
        .o_out   (corner_ch)
    );

    sqct_corner_checker #(
        .FRAC_BITS (FRAC_BITS)
    ) corner_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sprite     (sprite_ch),
        .i_corner     (corner_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_in_item make_sprite(
        input logic [15:0] px, input logic [15:0] py,
        input logic [11:0] hw, input logic [11:0] hh,
        input logic [15:0] pvx, input logic [15:0] pvy,
        input logic fx, input logic fy, input logic [8:0] ang);
        t_in_item s;
        s.pos_x       = px;
        s.pos_y       = py;
        s.half_width  = hw;
        s.half_height = hh;
        s.pivot_x     = pvx;
        s.pivot_y     = pvy;
        s.flip_x      = fx;
        s.flip_y      = fy;
        s.angle_deg   = ang;
        return s;
    endfunction

    // half full-range, half near the origin so most corners stay unsaturated
    function automatic logic [15:0] pick_coord();
        if ($urandom_range(0, 1) == 0) return 16'($urandom);
        return 16'(int'($urandom_range(0, 4095)) - 2048);
    endfunction

    function automatic logic [11:0] pick_half();
        if ($urandom_range(0, 3) == 0) return 12'($urandom);
        return 12'($urandom_range(0, 100));
    endfunction

    // one sprite transfer, with an optional idle burst ahead of it
    task automatic send_sprite(input t_in_item s);
        int unsigned gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            sprite_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sprite_ch.valid <= 1'b1;
        sprite_ch.data  <= s;
        @(posedge i_clk);
        while (!sprite_ch.ready) @(posedge i_clk);
        sprites_sent++;
    endtask

    // output back-pressure in random bursts
    initial begin
        corner_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!quiet && $urandom_range(0, 2) == 0) begin
                corner_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                corner_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 25)) @(posedge i_clk);
            end
        end
    end

    // watchdog: too long without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (sprite_ch.valid && sprite_ch.ready) ||
            (corner_ch.valid && corner_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_sprite_quad_corner_transform failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_in_item directed [$];
        i_rst_n         <= 1'b0;
        sprite_ch.valid <= 1'b0;
        sprite_ch.data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero sprite, then saturation at both ends
        directed = {directed, make_sprite(0, 0, 0, 0, 0, 0, 0, 0, 0)};
        directed = {directed, make_sprite(0, 0, 12'hFFF, 12'hFFF, 0, 0, 0, 0, 0)};
        directed = {directed, make_sprite(16'h7FFF, 16'h7FFF, 1, 1, 0, 0, 0, 0, 0)};
        directed = {directed, make_sprite(16'h8000, 16'h8000, 1, 1, 0, 0, 0, 0, 0)};
        directed = {directed, make_sprite(0, 0, 12'hFFF, 12'hFFF,
                                          16'h7FFF, 16'h8000, 0, 0, 0)};
        directed = {directed, make_sprite(16'h7FFF, 16'h8000, 12'hFFF, 12'hFFF,
                                          16'h8000, 16'h8000, 1, 1, 45)};
        // quadrant boundaries and odd angles
        directed = {directed, make_sprite(100, -200, 10, 20, 16, -48, 0, 0, 90)};
        directed = {directed, make_sprite(100, -200, 10, 20, 16, -48, 0, 0, 180)};
        directed = {directed, make_sprite(100, -200, 10, 20, 16, -48, 0, 0, 270)};
        directed = {directed, make_sprite(100, -200, 10, 20, 16, -48, 0, 0, 359)};
        directed = {directed, make_sprite(100, -200, 10, 20, 16, -48, 0, 0, 1)};
        directed = {directed, make_sprite(100, -200, 10, 20, 16, -48, 0, 0, 89)};
        // angles past a full turn wrap around
        directed = {directed, make_sprite(100, -200, 10, 20, 16, -48, 0, 0, 360)};
        directed = {directed, make_sprite(100, -200, 10, 20, 16, -48, 0, 0, 511)};
        directed = {directed, make_sprite(-50, 70, 33, 7, 5, 3, 0, 0, 405)};
        // flip combinations
        directed = {directed, make_sprite(-50, 70, 33, 7, 5, 3, 1, 0, 30)};
        directed = {directed, make_sprite(-50, 70, 33, 7, 5, 3, 0, 1, 30)};
        directed = {directed, make_sprite(-50, 70, 33, 7, 5, 3, 1, 1, 30)};
        // degenerate widths
        directed = {directed, make_sprite(0, 0, 0, 12'hFFF, 0, 0, 0, 0, 135)};
        directed = {directed, make_sprite(0, 0, 12'hFFF, 0, 0, 0, 1, 0, 225)};

        quiet_from = directed.size() + RANDOM_SPRITES - QUIET_TAIL;
        foreach (directed[i]) send_sprite(directed[i]);

        repeat (RANDOM_SPRITES) begin
            send_sprite(make_sprite(pick_coord(), pick_coord(), pick_half(),
                                    pick_half(), pick_coord(), pick_coord(),
                                    1'($urandom), 1'($urandom), 9'($urandom)));
        end
        sprite_ch.valid <= 1'b0;
        // let the checker count the last sprite before polling
        @(posedge i_clk);

        // drain, then let the pipeline settle
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("tb_sprite_quad_corner_transform passed");
        end else begin
            $display("tb_sprite_quad_corner_transform failed");
        end
        $finish;
    end

endmodule
